// ===== rtl/qnorm_pkg.sv =====
`default_nettype none
package qnorm_pkg;

  localparam int unsigned DefaultCompWidth = 16;
  localparam int unsigned TolWidth = 16;
  localparam logic [TolWidth-1:0] TolReset = 16'd1678;
  localparam int unsigned IntBits = 4;
  localparam int unsigned QueueDepth = 2;

  // Classification of one item, made by the front part.
  typedef enum logic [2:0] {
    KindZero = 3'b001,
    KindUnit = 3'b010,
    KindScale = 3'b100
  } kind_e;

endpackage
`default_nettype wire

// ===== rtl/qnorm_if.sv =====
`default_nettype none
interface qnorm_in_if #(
  parameter int unsigned CompWidth = 16
);
  logic valid;
  logic ready;
  logic signed [CompWidth-1:0] comp_x;
  logic signed [CompWidth-1:0] comp_y;
  logic signed [CompWidth-1:0] comp_z;
  logic signed [CompWidth-1:0] comp_w;
  modport source(output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink(input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface qnorm_out_if #(
  parameter int unsigned CompWidth = 16
);
  logic valid;
  logic ready;
  logic signed [CompWidth-1:0] out_x;
  logic signed [CompWidth-1:0] out_y;
  logic signed [CompWidth-1:0] out_z;
  logic signed [CompWidth-1:0] out_w;
  logic ok;
  logic was_scaled;
  modport source(output valid, out_x, out_y, out_z, out_w, ok, was_scaled, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_w, ok, was_scaled, output ready);
endinterface
`default_nettype wire

// ===== rtl/qnorm_front.sv =====
`default_nettype none
// Front part: squares the components, sums them and classifies the item.
// Two stages: squares, then sum and compare.
module qnorm_front import qnorm_pkg::*; #(
  parameter int unsigned CompWidth = DefaultCompWidth,
  localparam int unsigned MagWidth = CompWidth + 1,
  localparam int unsigned SumWidth = 2 * CompWidth + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [TolWidth-1:0]         tol_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [4*CompWidth-1:0]      in_comp_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [4*CompWidth-1:0]           out_comp_o,
  output logic [SumWidth-1:0]              out_sum_o,
  output kind_e                            out_kind_o
);
  localparam int unsigned SqWidth = 2 * CompWidth;
  localparam logic [SumWidth-1:0] One = SumWidth'(1) << (2 * (CompWidth - IntBits));

  logic s1_valid_q, s2_valid_q;
  logic [4*CompWidth-1:0] s1_comp_q, s2_comp_q;
  logic [SqWidth:0] s1_sq_q [4];
  logic [SumWidth-1:0] s2_sum_q;
  kind_e s2_kind_q;
  logic adv1, adv2;

  logic [MagWidth-1:0] mag [4];
  logic [SumWidth-1:0] sum_d, unit_dist;
  kind_e kind_d;

  assign adv2 = !s2_valid_q || out_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  // Absolute values of the components.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = in_comp_i[i*CompWidth+CompWidth-1]
             ? MagWidth'(-$signed({1'b1, in_comp_i[i*CompWidth +: CompWidth]}))
             : MagWidth'(in_comp_i[i*CompWidth +: CompWidth]);
    end
  end

  // Sum and classification of the registered squares.
  always_comb begin
    sum_d = SumWidth'(s1_sq_q[0]) + SumWidth'(s1_sq_q[1])
          + SumWidth'(s1_sq_q[2]) + SumWidth'(s1_sq_q[3]);
    unit_dist = (sum_d >= One) ? sum_d - One : One - sum_d;
    if (sum_d == '0) begin
      kind_d = KindZero;
    end else if (unit_dist <= SumWidth'(tol_i)) begin
      kind_d = KindUnit;
    end else begin
      kind_d = KindScale;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_comp_q <= in_comp_i;
      for (int i = 0; i < 4; i++) s1_sq_q[i] <= (SqWidth+1)'(mag[i] * mag[i]);
    end
    if (adv2) begin
      s2_comp_q <= s1_comp_q;
      s2_sum_q <= sum_d;
      s2_kind_q <= kind_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_comp_o = s2_comp_q;
  assign out_sum_o = s2_sum_q;
  assign out_kind_o = s2_kind_q;
endmodule
`default_nettype wire

// ===== rtl/qnorm_queue.sv =====
`default_nettype none
// Short queue between the front and back parts.
module qnorm_queue import qnorm_pkg::*; #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth = QueueDepth,
  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_valid_i,
  output logic                      wr_ready_o,
  input  wire logic [DataWidth-1:0] wr_data_i,
  output logic                      rd_valid_o,
  input  wire logic                 rd_ready_i,
  output logic [DataWidth-1:0]      rd_data_o
);
  logic [DataWidth-1:0] mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0] count_q;
  logic do_wr, do_rd;

  assign wr_ready_o = count_q != (PtrWidth+1)'(Depth);
  assign rd_valid_o = count_q != '0;
  assign do_wr = wr_valid_i && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrWidth+1)'(do_wr) - (PtrWidth+1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// ===== rtl/qnorm_back.sv =====
`default_nettype none
// Back part: a pipelined square root, then four pipelined dividers that
// round the quotient to nearest. Each root and divide stage resolves one result bit.
module qnorm_back import qnorm_pkg::*; #(
  parameter int unsigned CompWidth = DefaultCompWidth,
  localparam int unsigned SumWidth = 2 * CompWidth + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [4*CompWidth-1:0] in_comp_i,
  input  wire logic [SumWidth-1:0]    in_sum_i,
  input  wire kind_e                  in_kind_i,
  qnorm_out_if.source                 res
);
  localparam int unsigned FracBits = CompWidth - IntBits;
  localparam int unsigned RootWidth = CompWidth + 1;
  localparam int unsigned RootSteps = RootWidth;
  // Quotient of 2*mag*2^F/(2R) never exceeds 2^(F+1), so F+2 bits.
  localparam int unsigned QWidth = FracBits + 2;
  localparam int unsigned NumWidth = CompWidth + FracBits + 2;
  localparam int unsigned DenWidth = RootWidth + 1;
  // Root stages, one stage to set up the dividers, then the divide stages.
  localparam int unsigned Stages = RootSteps + 1 + QWidth;
  localparam int unsigned RemWidth = SumWidth + 2;

  typedef struct packed {
    logic [4*CompWidth-1:0] comp;
    kind_e kind;
  } side_t;

  logic adv;
  logic [Stages:0] vld_q;
  side_t side_q [Stages+1];
  // Square root stages.
  logic [SumWidth-1:0] rem_q [RootSteps+1];
  logic [RootWidth-1:0] root_q [RootSteps+1];
  // Division stages.
  logic [NumWidth-1:0] num_q [4][QWidth+1];
  logic [QWidth-1:0] quo_q [4][QWidth+1];
  logic [DenWidth-1:0] den_q [QWidth+1];

  logic out_valid_q;
  logic [4*CompWidth-1:0] out_comp_q;
  logic out_ok_q, out_scaled_q;

  assign adv = !out_valid_q || res.ready;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-1:0], in_valid_i};
      out_valid_q <= vld_q[Stages];
    end
  end

  // Stage inputs.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{comp: in_comp_i, kind: in_kind_i};
      rem_q[0] <= in_sum_i;
      root_q[0] <= '0;
      for (int s = 1; s <= Stages; s++) side_q[s] <= side_q[s-1];
    end
  end

  // Restoring square root, one root bit a stage, most significant first.
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam int unsigned B = RootSteps - 1 - k;
    logic [RemWidth-1:0] trial;
    logic [RootWidth-1:0] cand;
    always_comb begin
      cand = root_q[k] | (RootWidth'(1) << B);
      trial = RemWidth'(cand) * RemWidth'(cand);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1] <= rem_q[k];
        root_q[k+1] <= (trial <= RemWidth'(rem_q[k])) ? cand : root_q[k];
      end
    end
  end

  // Divider inputs: numerator 2*mag*2^F + R, denominator 2R.
  for (genvar c = 0; c < 4; c++) begin : g_lane
    logic [CompWidth:0] mag;
    assign mag = side_q[RootSteps].comp[c*CompWidth+CompWidth-1]
               ? (CompWidth+1)'(-$signed({1'b1,
                   side_q[RootSteps].comp[c*CompWidth +: CompWidth]}))
               : (CompWidth+1)'(side_q[RootSteps].comp[c*CompWidth +: CompWidth]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        num_q[c][0] <= (NumWidth'(mag) << (FracBits + 1))
                     + NumWidth'(root_q[RootSteps]);
        quo_q[c][0] <= '0;
      end
    end
    // Restoring division, one quotient bit a stage.
    for (genvar k = 0; k < QWidth; k++) begin : g_div
      localparam int unsigned B = QWidth - 1 - k;
      logic [NumWidth-1:0] part;
      always_comb part = num_q[c][k] >> B;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (part >= NumWidth'(den_q[k])) begin
            num_q[c][k+1] <= num_q[c][k] - (NumWidth'(den_q[k]) << B);
            quo_q[c][k+1] <= quo_q[c][k] | (QWidth'(1) << B);
          end else begin
            num_q[c][k+1] <= num_q[c][k];
            quo_q[c][k+1] <= quo_q[c][k];
          end
        end
      end
      if (c == 0) begin : g_den
        always_ff @(posedge clk_i) begin
          if (adv) den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q[0] <= {root_q[RootSteps], 1'b0};
    end
  end

  // Result register: pass-through or signed quotient.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ok_q <= side_q[Stages].kind != KindZero;
      out_scaled_q <= side_q[Stages].kind == KindScale;
      for (int c = 0; c < 4; c++) begin
        if (side_q[Stages].kind == KindScale) begin
          out_comp_q[c*CompWidth +: CompWidth] <=
            side_q[Stages].comp[c*CompWidth+CompWidth-1]
              ? CompWidth'(-$signed({1'b0, quo_q[c][QWidth]}))
              : CompWidth'(quo_q[c][QWidth]);
        end else begin
          out_comp_q[c*CompWidth +: CompWidth] <= side_q[Stages].comp[c*CompWidth +: CompWidth];
        end
      end
    end
  end

  assign res.valid = out_valid_q;
  assign res.out_x = out_comp_q[0*CompWidth +: CompWidth];
  assign res.out_y = out_comp_q[1*CompWidth +: CompWidth];
  assign res.out_z = out_comp_q[2*CompWidth +: CompWidth];
  assign res.out_w = out_comp_q[3*CompWidth +: CompWidth];
  assign res.ok = out_ok_q;
  assign res.was_scaled = out_scaled_q;
endmodule
`default_nettype wire

// ===== rtl/quaternion_normalizer.sv =====
`default_nettype none
// Quaternion normaliser. Takes one item a cycle while not stalled and returns one
// result per item, in order. The path from acceptance to a valid result is: two
// front stages, the queue memory, the back part's input register, CompWidth + 1
// square root stages, one stage to set up the dividers, CompWidth - 2 divide
// stages and the result register. A stalled result holds the whole back part.
// Items whose squared magnitude is zero, or within the tolerance register's value
// of one, pass through unchanged.
module quaternion_normalizer import qnorm_pkg::*; #(
  parameter int unsigned CompWidth = DefaultCompWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TolWidth-1:0] cfg_wdata_i,
  qnorm_in_if.sink                 req,
  qnorm_out_if.source              res
);
  localparam int unsigned SumWidth = 2 * CompWidth + 1;
  localparam int unsigned QW = 4 * CompWidth + SumWidth + 3;

  logic [TolWidth-1:0] tol_q;
  logic f_valid, f_ready, b_valid, b_ready;
  logic [4*CompWidth-1:0] f_comp;
  logic [SumWidth-1:0] f_sum;
  kind_e f_kind;
  logic [QW-1:0] q_rd;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  qnorm_front #(.CompWidth(CompWidth)) u_front (
    .clk_i, .rst_ni, .tol_i(tol_q),
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .in_comp_i({req.comp_w, req.comp_z, req.comp_y, req.comp_x}),
    .out_valid_o(f_valid), .out_ready_i(f_ready),
    .out_comp_o(f_comp), .out_sum_o(f_sum), .out_kind_o(f_kind)
  );

  qnorm_queue #(.DataWidth(QW), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i({f_comp, f_sum, f_kind}),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(q_rd)
  );

  qnorm_back #(.CompWidth(CompWidth)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(b_valid), .in_ready_o(b_ready),
    .in_comp_i(q_rd[QW-1 -: 4*CompWidth]),
    .in_sum_i(q_rd[SumWidth+2:3]),
    .in_kind_i(kind_e'(q_rd[2:0])),
    .res(res)
  );
endmodule
`default_nettype wire

// ===== rtl/qnorm_checker.sv =====
`default_nettype none
// Port-level checks of the normaliser.
module qnorm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_ok,
  input wire logic res_was_scaled
);
  // A scaled result always reports a nonzero magnitude.
  a_scaled_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_was_scaled |-> res_ok) else $error("scaled without ok");

  // A stalled result keeps its flags.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_was_scaled))
    else $error("result changed under stall");

  // No result straight out of reset.
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !res_valid)
    else $error("result right after reset");
endmodule

bind quaternion_normalizer qnorm_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_ok(res.ok), .res_was_scaled(res.was_scaled)
);
`default_nettype wire

// ===== test/tb_quaternion_normalizer.sv =====
module tb_quaternion_normalizer;
  import qnorm_pkg::*;

  localparam int unsigned Cw = DefaultCompWidth;
  localparam int unsigned FracBits = Cw - IntBits;
  localparam int RandItems = 1600;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  // One normalised quaternion as the block should return it.
  typedef struct packed {
    logic [Cw-1:0] x;
    logic [Cw-1:0] y;
    logic [Cw-1:0] z;
    logic [Cw-1:0] w;
    logic ok;
    logic was_scaled;
  } quat_res_t;

  // One row of the directed table; check_lit says whether lit_res is used.
  typedef struct {
    logic [Cw-1:0] c[4];
    logic check_lit;
    quat_res_t lit_res;
  } quat_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TolWidth-1:0] cfg_wdata_i;

  qnorm_in_if #(.CompWidth(Cw)) req ();
  qnorm_out_if #(.CompWidth(Cw)) res ();

  quaternion_normalizer #(.CompWidth(Cw)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req.sink),
    .res        (res.source)
  );

  logic [TolWidth-1:0] tolerance;
  quat_res_t pending_norms[$];
  int mismatches;
  int cycles;
  bit hold_off_res;
  bit stall_free;
  bit long_hold_req;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Integer square root, floor, by the bit-pair method.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected result for one input quaternion under the current tolerance.
  function automatic quat_res_t normalise(input logic [Cw-1:0] c[4]);
    logic [64:0] sum;
    logic [63:0] mag[4];
    logic [63:0] unit_sq;
    logic [64:0] unit_dist;
    logic [63:0] root;
    logic [63:0] q;
    logic [Cw-1:0] o[4];
    quat_res_t r;
    sum = 0;
    unit_sq = 64'd1 << (2 * FracBits);
    for (int i = 0; i < 4; i++) begin
      mag[i] = c[i][Cw-1] ? ((64'd1 << Cw) - 64'(c[i])) : 64'(c[i]);
      sum = sum + 65'(mag[i] * mag[i]);
    end
    r.ok = (sum != 0);
    r.was_scaled = 1'b0;
    for (int i = 0; i < 4; i++) o[i] = c[i];
    if (sum != 0) begin
      unit_dist = (sum >= 65'(unit_sq)) ? sum - 65'(unit_sq) : 65'(unit_sq) - sum;
      if (unit_dist > 65'(tolerance)) begin
        r.was_scaled = 1'b1;
        root = sum[64] ? (64'd1 << 32) : floor_sqrt(sum[63:0]);
        for (int i = 0; i < 4; i++) begin
          q = (2 * (mag[i] << FracBits) + root) / (2 * root);
          o[i] = c[i][Cw-1] ? Cw'(-q) : Cw'(q);
        end
      end
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.w = o[3];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [Cw-1:0] got,
                                 input logic [Cw-1:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Send one item and record its expected result.
  task automatic send_quat(input logic [Cw-1:0] c[4], input bit use_lit,
                           input quat_res_t lit);
    req.valid <= 1'b1;
    req.comp_x <= c[0];
    req.comp_y <= c[1];
    req.comp_z <= c[2];
    req.comp_w <= c[3];
    pending_norms.push_back(use_lit ? lit : normalise(c));
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Random idle burst on the sending side.
  task automatic maybe_idle();
    if (!stall_free && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TolWidth-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tolerance = v;
  endtask

  // Random quaternion: raw bits, components in [-1, 1], small values or near unit on one axis.
  function automatic void random_quat(output logic [Cw-1:0] c[4]);
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (k < 4) c[i] = Cw'($urandom);
      else if (k < 6) c[i] = Cw'($signed($urandom_range(0, 2 << FracBits)) - (1 << FracBits));
      else if (k < 8) c[i] = Cw'($signed($urandom_range(0, 64)) - 32);
      else c[i] = 0;
    end
    // Make an exact or near unit quaternion on one axis.
    if (k >= 8) c[$urandom_range(0, 3)] = Cw'(($urandom_range(0, 1) ? 1 : -1) *
        ((1 << FracBits) + $signed($urandom_range(0, 4)) - 2));
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("quaternion_normalizer: mismatch");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_res) begin
        res.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off_res = 1'b0;
      end else if (!stall_free && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    quat_res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_norms.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_norms.pop_front();
        if (res.out_x !== want.x) report_mismatch("out_x", res.out_x, want.x);
        if (res.out_y !== want.y) report_mismatch("out_y", res.out_y, want.y);
        if (res.out_z !== want.z) report_mismatch("out_z", res.out_z, want.z);
        if (res.out_w !== want.w) report_mismatch("out_w", res.out_w, want.w);
        if (res.ok !== want.ok) report_mismatch("ok", Cw'(res.ok), Cw'(want.ok));
        if (res.was_scaled !== want.was_scaled)
          report_mismatch("was_scaled", Cw'(res.was_scaled), Cw'(want.was_scaled));
      end
    end
  end

  // Stimulus.
  initial begin
    quat_row_t rows[$];
    quat_row_t row;
    quat_res_t none;
    logic [Cw-1:0] c[4];
    logic [Cw-1:0] mx;
    logic [Cw-1:0] mn;
    logic [Cw-1:0] one;
    mismatches = 0;
    cycles = 0;
    hold_off_res = 1'b0;
    stall_free = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.comp_x = '0;
    req.comp_y = '0;
    req.comp_z = '0;
    req.comp_w = '0;
    tolerance = TolReset;
    none = '0;
    mx = {1'b0, {(Cw-1){1'b1}}};
    mn = {1'b1, {(Cw-1){1'b0}}};
    one = Cw'(1 << FracBits);

    // Directed table: zero, exact unit, extremes, ties and general cases.
    row.check_lit = 1'b1;
    row.c = '{0, 0, 0, 0};
    row.lit_res = '{x: 0, y: 0, z: 0, w: 0, ok: 0, was_scaled: 0};
    rows.push_back(row);
    row.c = '{0, 0, 0, one};
    row.lit_res = '{x: 0, y: 0, z: 0, w: one, ok: 1, was_scaled: 0};
    rows.push_back(row);
    row.c = '{-one, 0, 0, 0};
    row.lit_res = '{x: -one, y: 0, z: 0, w: 0, ok: 1, was_scaled: 0};
    rows.push_back(row);
    row.c = '{mn, mn, mn, mn};
    row.lit_res = '{x: -(one >> 1), y: -(one >> 1), z: -(one >> 1), w: -(one >> 1),
                    ok: 1, was_scaled: 1};
    rows.push_back(row);
    row.c = '{0, mn, 0, 0};
    row.lit_res = '{x: 0, y: -one, z: 0, w: 0, ok: 1, was_scaled: 1};
    rows.push_back(row);
    row.c = '{2 * one, 0, 0, 0};
    row.lit_res = '{x: one, y: 0, z: 0, w: 0, ok: 1, was_scaled: 1};
    rows.push_back(row);
    row.check_lit = 1'b0;
    row.c = '{mx, mx, mx, mx}; rows.push_back(row);
    row.c = '{1, 0, 0, 0}; rows.push_back(row);
    row.c = '{16'hffff, 16'hffff, 1, 1}; rows.push_back(row);
    row.c = '{3, 4, 0, 0}; rows.push_back(row);
    row.c = '{one + 1, 0, 0, 0}; rows.push_back(row);
    row.c = '{one + 2, 0, 0, 0}; rows.push_back(row);
    row.c = '{mx, mn, 16'h5555, 16'haaaa}; rows.push_back(row);
    row.c = '{16'h1000, 16'hf000, 16'h1000, 16'hf000}; rows.push_back(row);
    row.c = '{0, 0, 16'h7, 16'h0fff}; rows.push_back(row);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_quat(rows[i].c, rows[i].check_lit, rows[i].lit_res);
      maybe_idle();
    end
    wait_drained();

    // A long receiver hold-off while the sender sends without idle gaps.
    hold_off_res = 1'b1;
    for (int n = 0; n < 100; n++) begin
      random_quat(c);
      send_quat(c, 1'b0, none);
    end
    wait_drained();

    // Random phases over several tolerance settings, the extremes among them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_tolerance('0);
        1: write_tolerance('1);
        2: write_tolerance(TolWidth'($urandom));
        default: write_tolerance(TolReset);
      endcase
      for (int n = 0; n < RandItems / 4; n++) begin
        if (ph == 3 && n > RandItems / 8) stall_free = 1'b1;
        random_quat(c);
        send_quat(c, 1'b0, none);
        maybe_idle();
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("quaternion_normalizer: match");
    end else begin
      $display("quaternion_normalizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qnorm_pkg.sv
rtl/qnorm_if.sv
rtl/qnorm_front.sv
rtl/qnorm_queue.sv
rtl/qnorm_back.sv
rtl/quaternion_normalizer.sv
rtl/qnorm_checker.sv
test/tb_quaternion_normalizer.sv
